// ===== hw/rtl/nsc_pkg.sv =====
`timescale 1ns / 1ps

package nsc_pkg;

    // Default position of the checksum field in the field counter
    localparam int NSC_FIELD_MARK_DEFAULT = 100;

    // Character codes
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_ASTERISK  = 8'h2A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_LINE_FEED = 8'h0A;

    // Saturation limits and the digit value of a non-hex character
    localparam logic [7:0]  FIELD_MAX  = 8'hFF;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [7:0]  NON_HEX    = 8'hFF;

    // Per-sentence state
    typedef struct packed {
        logic [7:0]  field_index;
        logic [15:0] char_count;
        logic [7:0]  calc_checksum;
        logic [7:0]  recv_checksum;
    } nsc_state_t;

    // Value of a hex digit, or NON_HEX for anything else
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= 8'h30 && c <= 8'h39)
            begin
                v = c - 8'h30;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                v = c - 8'h57;
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                v = c - 8'h37;
            end
            else
            begin
                v = NON_HEX;
            end
            return v;
        end
    endfunction

endpackage

// ===== hw/rtl/nsc_if.sv =====
`timescale 1ns / 1ps

// Received character channel
interface nsc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

// Per-character status channel
interface nsc_status_if;
    logic        valid;
    logic        ready;
    logic        sentence_ok;
    logic [7:0]  field_index;
    logic [15:0] char_count;
    logic [7:0]  calc_checksum;
    logic [7:0]  recv_checksum;

    modport source (output valid, output sentence_ok, output field_index,
                    output char_count, output calc_checksum, output recv_checksum,
                    input ready);
    modport sink   (input valid, input sentence_ok, input field_index,
                    input char_count, input calc_checksum, input recv_checksum,
                    output ready);
endinterface

// ===== hw/rtl/nsc_update.sv =====
`timescale 1ns / 1ps

module nsc_update
    import nsc_pkg::*;
#(
    parameter int CHECKSUM_FIELD_MARK = NSC_FIELD_MARK_DEFAULT
)
(
    input  nsc_state_t state,
    input  logic [7:0] ch,
    output nsc_state_t state_next,
    output logic       sentence_ok
);

    localparam logic [7:0] MARK = 8'(CHECKSUM_FIELD_MARK);

    nsc_state_t base;
    logic       printable;

    always_comb
    begin
        // Apply control characters first
        base = state;
        case (ch)
            CH_DOLLAR:
            begin
                base = '0;
            end
            CH_COMMA:
            begin
                if (state.field_index != FIELD_MAX)
                begin
                    base.field_index = state.field_index + 8'd1;
                end
            end
            CH_ASTERISK:
            begin
                base.field_index = MARK;
            end
            default:
            begin
                base = state;
            end
        endcase

        // Fold printable characters into the checksums and the count
        printable  = (ch >= CH_SPACE) && (ch <= CH_TILDE);
        state_next = base;
        if (printable)
        begin
            if (base.field_index < MARK)
            begin
                if (ch != CH_DOLLAR && ch != CH_ASTERISK)
                begin
                    state_next.calc_checksum = base.calc_checksum ^ ch;
                end
            end
            else
            begin
                state_next.recv_checksum = {base.recv_checksum[3:0], 4'b0000}
                                           + hex_value(ch);
            end
            if (base.char_count != COUNT_MAX)
            begin
                state_next.char_count = base.char_count + 16'd1;
            end
        end

        sentence_ok = (ch == CH_LINE_FEED)
                      && (state_next.calc_checksum == state_next.recv_checksum);
    end

endmodule

// ===== hw/rtl/nmea_sentence_checksum_checker.sv =====
`timescale 1ns / 1ps

// NMEA sentence checksum checker. Feed received bytes on rx, one per
// transaction; every byte yields one status transaction on status carrying
// the field index, printable character count, computed XOR checksum and the
// checksum parsed from the hex digits after the asterisk, plus sentence_ok,
// which is high only for a line feed whose two checksums agree. A dollar
// sign starts a new sentence. Throughput is one character per clock cycle
// while status is ready; each accepted character passes through an input
// register, then the combinational state update feeding the output
// register. Backpressure on status stalls the two stages without losing data.

module nmea_sentence_checksum_checker
    import nsc_pkg::*;
#(
    parameter int CHECKSUM_FIELD_MARK = NSC_FIELD_MARK_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    nsc_char_if.sink     rx,
    nsc_status_if.source status
);

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_advance;

    nsc_state_t state_reg;
    nsc_state_t state_next;
    logic       ok_next;

    logic       out_valid_reg;
    logic       out_ok_reg;
    nsc_state_t out_state_reg;

    // Stage handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || status.ready);
    assign rx.ready   = !s1_valid_reg || s1_advance;

    // Capture the input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            s1_char_reg <= rx.rx_char;
        end
    end

    nsc_update #(
        .CHECKSUM_FIELD_MARK (CHECKSUM_FIELD_MARK)
    ) u_update (
        .state       (state_reg),
        .ch          (s1_char_reg),
        .state_next  (state_next),
        .sentence_ok (ok_next)
    );

    // Advance sentence state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                state_reg <= state_next;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the status payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_ok_reg    <= ok_next;
            out_state_reg <= state_next;
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.sentence_ok   = out_ok_reg;
    assign status.field_index   = out_state_reg.field_index;
    assign status.char_count    = out_state_reg.char_count;
    assign status.calc_checksum = out_state_reg.calc_checksum;
    assign status.recv_checksum = out_state_reg.recv_checksum;

`ifndef SYNTHESIS
    // A good sentence always reports matching checksums
    assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && status.sentence_ok
            |-> status.calc_checksum == status.recv_checksum)
        else $error("sentence_ok with mismatched checksums");

    // Non-printable characters leave the sentence state untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_char_reg < CH_SPACE || s1_char_reg > CH_TILDE)
            |=> $stable(state_reg))
        else $error("non-printable character changed state");

    // Character count only drops on a new sentence
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_char_reg != CH_DOLLAR
            |=> state_reg.char_count >= $past(state_reg.char_count))
        else $error("character count decreased");

    // An empty input stage always takes a new character
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> rx.ready)
        else $error("input stalled while empty");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import nsc_pkg::*;

    localparam int         FIELD_MARK     = NSC_FIELD_MARK_DEFAULT;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         REPORT_LIMIT   = 100;
    localparam logic [7:0] CH_CR          = 8'h0D;

    // One status transaction as the block should produce it
    typedef struct packed {
        logic        ok;
        logic [7:0]  fld;
        logic [15:0] cnt;
        logic [7:0]  calc;
        logic [7:0]  recv;
    } status_t;

    logic clk;
    logic rst_n;

    nsc_char_if   rx_if ();
    nsc_status_if st_if ();

    nmea_sentence_checksum_checker #(
        .CHECKSUM_FIELD_MARK(FIELD_MARK)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .status (st_if)
    );

    // Sentence state tracked alongside the block
    logic [7:0]  field_now;
    logic [7:0]  xor_now;
    logic [7:0]  hex_now;
    logic [15:0] count_now;

    status_t status_expected_q[$];
    status_t got;
    status_t want;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_ask;
    int stall_left;
    int quiet_cycles   = 0;
    int err_count      = 0;
    int chars_sent;
    int status_checked = 0;
    int sentences_ok   = 0;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Digit value of a hex character, 255 for anything else
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'hFF;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h41 + 8'd10;
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h61 + 8'd10;
        end
        return v;
    endfunction

    // Advance the tracked sentence state by one character and queue the status
    task automatic predict_status(input logic [7:0] c);
        status_t s;
        if (c == CH_DOLLAR)
        begin
            field_now = 8'd0;
            xor_now   = 8'd0;
            hex_now   = 8'd0;
            count_now = 16'd0;
        end
        else if (c == CH_COMMA)
        begin
            if (field_now != FIELD_MAX)
            begin
                field_now = field_now + 8'd1;
            end
        end
        else if (c == CH_ASTERISK)
        begin
            field_now = 8'(FIELD_MARK);
        end

        if (c >= CH_SPACE && c <= CH_TILDE)
        begin
            if (field_now < FIELD_MARK)
            begin
                if (c != CH_DOLLAR && c != CH_ASTERISK)
                begin
                    xor_now = xor_now ^ c;
                end
            end
            else
            begin
                hex_now = {hex_now[3:0], 4'h0} + digit_value(c);
            end
            if (count_now != COUNT_MAX)
            begin
                count_now = count_now + 16'd1;
            end
        end

        s.ok   = (c == CH_LINE_FEED) && (xor_now == hex_now);
        s.fld  = field_now;
        s.cnt  = count_now;
        s.calc = xor_now;
        s.recv = hex_now;
        status_expected_q.push_back(s);
    endtask

    // Offer one character, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_char <= c;
        @(posedge clk);
        while (!rx_if.ready)
        begin
            @(posedge clk);
        end
        predict_status(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        logic [7:0] base;
        base = lower ? 8'h61 : 8'h41;
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return base + 8'(n) - 8'd10;
    endfunction

    // Printable sentence text, never a dollar or an asterisk, commas often
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(3) == 0)
        begin
            return CH_COMMA;
        end
        do
        begin
            c = 8'($urandom_range(CH_SPACE, CH_TILDE));
        end
        while (c == CH_DOLLAR || c == CH_ASTERISK);
        return c;
    endfunction

    // Full sentence with its checksum; a corrupt one gets a single bit flipped
    task automatic send_sentence(input int body_len, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] c;
        bit         lower;
        int         i;
        sum   = 8'd0;
        lower = $urandom_range(1);
        send_char(CH_DOLLAR);
        for (i = 0; i < body_len; i++)
        begin
            c   = text_char();
            sum = sum ^ c;
            send_char(c);
        end
        if (corrupt)
        begin
            sum = sum ^ (8'h01 << $urandom_range(7));
        end
        send_char(CH_ASTERISK);
        // a stray leading digit is shifted out by the two that follow
        if ($urandom_range(7) == 0)
        begin
            send_char(hex_char(4'($urandom_range(15)), lower));
        end
        send_char(hex_char(sum[7:4], lower));
        send_char(hex_char(sum[3:0], lower));
        if ($urandom_range(1) == 1)
        begin
            send_char(CH_CR);
        end
        send_char(CH_LINE_FEED);
    endtask

    // Sentence cut short, ended early or followed by junk after the asterisk
    task automatic send_broken();
        send_char(CH_DOLLAR);
        repeat ($urandom_range(0, 12))
        begin
            send_char(text_char());
        end
        case ($urandom_range(2))
            0:
            begin
                send_char(CH_LINE_FEED);
            end
            1:
            begin
                send_char(CH_ASTERISK);
                repeat ($urandom_range(1, 4))
                begin
                    send_char(8'($urandom_range(CH_SPACE, CH_TILDE)));
                end
                send_char(CH_LINE_FEED);
            end
            default:
            begin
            end
        endcase
    endtask

    // Drop valid and hold until every queued status has come back
    task automatic drain_status();
        rx_if.valid <= 1'b0;
        while (status_expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Byte extremes, a line feed straight after reset, two checked sentences,
    // non-hex digits after the asterisk, a repeated asterisk
    task automatic test_directed();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(8'h1F);
        send_char(CH_LINE_FEED);
        send_text("$~ ,A*33");
        send_char(CH_LINE_FEED);
        send_text("$|*7c");
        send_char(CH_LINE_FEED);
        send_text("*G1");
        send_char(CH_LINE_FEED);
        send_char(CH_DOLLAR);
        send_char(CH_ASTERISK);
        send_char(CH_ASTERISK);
    endtask

    // Mostly good sentences, some broken ones, some raw noise
    task automatic test_random_stream(input int n_chars);
        int start;
        int kind;
        int len;
        start = chars_sent;
        while (chars_sent - start < n_chars)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
                send_sentence(len, $urandom_range(9) == 0);
            end
            else if (kind < 85)
            begin
                send_broken();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_char(8'($urandom_range(255)));
                end
            end
        end
    endtask

    // Long receiver hold-off with the sender still offering, then a full drain
    task automatic test_backpressure();
        stall_ask = 300;
        send_sentence(60, 1'b0);
        drain_status();
        send_sentence(8, 1'b0);
        drain_status();
        send_sentence(5, 1'b0);
    endtask

    // Enough commas to pin the field counter at its top, then the asterisk
    task automatic test_field_saturation();
        send_char(CH_DOLLAR);
        repeat (260)
        begin
            send_char(CH_COMMA);
        end
        send_char(CH_COMMA);
        send_text("*00");
        send_char(CH_LINE_FEED);
    endtask

    // Receiver side: random ready, or a counted hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (stall_ask != 0)
            begin
                stall_left = stall_ask;
                stall_ask  = 0;
            end
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                st_if.ready <= 1'b0;
            end
            else
            begin
                st_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            if (err_count < REPORT_LIMIT)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            end
            err_count++;
        end
    endtask

    // Compare every status transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && st_if.valid && st_if.ready)
        begin
            got.ok   = st_if.sentence_ok;
            got.fld  = st_if.field_index;
            got.cnt  = st_if.char_count;
            got.calc = st_if.calc_checksum;
            got.recv = st_if.recv_checksum;
            if (status_expected_q.size() == 0)
            begin
                $display("%0t: status with nothing expected, got %0h", $time, got);
                err_count++;
            end
            else
            begin
                want = status_expected_q.pop_front();
                check_field("sentence_ok", 16'(want.ok), 16'(got.ok));
                check_field("field_index", 16'(want.fld), 16'(got.fld));
                check_field("char_count", want.cnt, got.cnt);
                check_field("calc_checksum", 16'(want.calc), 16'(got.calc));
                check_field("recv_checksum", 16'(want.recv), 16'(got.recv));
                status_checked++;
                if (got.ok)
                begin
                    sentences_ok++;
                end
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n && !((rx_if.valid && rx_if.ready) || (st_if.valid && st_if.ready)))
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
        else
        begin
            quiet_cycles = 0;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_char  = 8'h00;
        field_now      = 8'd0;
        xor_now        = 8'd0;
        hex_now        = 8'd0;
        count_now      = 16'd0;
        send_idle_pct  = 17;
        recv_idle_pct  = 45;
        stall_ask      = 0;
        chars_sent     = 0;

        repeat (3)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        test_directed();
        test_random_stream(500);
        test_backpressure();

        // swap the idle rates
        send_idle_pct = 45;
        recv_idle_pct = 17;
        test_random_stream(500);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(500);
        test_field_saturation();

        drain_status();
        repeat (8)
        begin
            @(posedge clk);
        end
        if (status_expected_q.size() != 0)
        begin
            $display("%0t: %0d status transactions never arrived", $time,
                     status_expected_q.size());
            err_count++;
        end

        $display("Sent %0d characters: directed, random sentences, noise, back-pressure,",
                 chars_sent);
        $display("field saturation; %0d statuses checked, %0d sentences accepted",
                 status_checked, sentences_ok);
        if (err_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
